/* sv/vpaa_pkg.sv */
package vpaa_pkg;

   localparam int DIM         = 3;
   localparam int COORD_W     = 32;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int WIDE_W      = 4 * COORD_W;
   localparam int OUT_W       = 32;
   localparam int Q_W         = 31;
   localparam int QUO_W       = 2 * (Q_W - 1) + 1;
   localparam int DIV_STEPS   = QUO_W;
   localparam int SQRT_STEPS  = Q_W;
   localparam int RATIO_LAT   = DIV_STEPS + SQRT_STEPS;
   localparam int NLANE       = 2 + DIM;
   localparam int THR_W       = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [THR_W-1:0] THR_RESET = 16'd1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO     = 2'd1,
      STAT_PARALLEL = 2'd2
   } status_type;

   typedef struct packed {
      logic [DIM-1:0][COORD_W-1:0] a;
      logic [DIM-1:0][COORD_W-1:0] b;
      logic                        zero_len;
   } item_type;

   typedef struct packed {
      logic           zero_len;
      logic           dot_neg;
      logic [DIM-1:0] cr_neg;
      logic           c2_zero;
   } side_type;

endpackage

/* sv/vpaa_front.sv */
module vpaa_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vpaa_pkg::COORD_W-1:0] req_a_x,
   input  logic [vpaa_pkg::COORD_W-1:0] req_a_y,
   input  logic [vpaa_pkg::COORD_W-1:0] req_a_z,
   input  logic [vpaa_pkg::COORD_W-1:0] req_b_x,
   input  logic [vpaa_pkg::COORD_W-1:0] req_b_y,
   input  logic [vpaa_pkg::COORD_W-1:0] req_b_z,
   input  logic                         full,
   output logic                         push_valid,
   output vpaa_pkg::item_type           push_data
);
   import vpaa_pkg::*;

   logic a_zero;
   logic b_zero;

   // a zero vector leaves a zero length; the back end masks the quotients
   assign a_zero = (req_a_x == '0) && (req_a_y == '0) && (req_a_z == '0);
   assign b_zero = (req_b_x == '0) && (req_b_y == '0) && (req_b_z == '0);

   always_comb begin
      push_data.a[0]    = req_a_x;
      push_data.a[1]    = req_a_y;
      push_data.a[2]    = req_a_z;
      push_data.b[0]    = req_b_x;
      push_data.b[1]    = req_b_y;
      push_data.b[2]    = req_b_z;
      push_data.zero_len = a_zero || b_zero;
   end

   assign req_stall  = full;
   assign push_valid = req_valid && !full;

endmodule

/* sv/vpaa_queue.sv */
module vpaa_queue #(
   parameter int DEPTH = vpaa_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  vpaa_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output vpaa_pkg::item_type head
);
   import vpaa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/vpaa_ratio.sv */
// q = isqrt(floor(num * 2^60 / den)): restoring divide, then digit-by-digit root.
module vpaa_ratio (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [vpaa_pkg::WIDE_W-1:0] num,
   input  logic [vpaa_pkg::WIDE_W-1:0] den,
   output logic [vpaa_pkg::Q_W-1:0]    quotient
);
   import vpaa_pkg::*;

   localparam int SQ_W = 2 * Q_W + 1;

   logic [WIDE_W-1:0] rem_ff [DIV_STEPS-1];
   logic [WIDE_W-1:0] den_ff [DIV_STEPS-1];
   logic [QUO_W-1:0]  quo_ff [DIV_STEPS];
   logic [QUO_W-1:0]  sr_ff  [SQRT_STEPS-1];
   logic [Q_W-1:0]    rt_ff  [SQRT_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [WIDE_W:0]   r2;
      logic [WIDE_W:0]   dext;
      logic [WIDE_W-1:0] d_cur;
      logic [QUO_W-1:0]  quo_in;
      logic              ge;

      // num <= den always, so the first step needs no shift
      if (k == 0) begin : g_first
         assign r2     = {1'b0, num};
         assign d_cur  = den;
         assign quo_in = QUO_W'(ge);
      end else begin : g_next
         assign r2     = {rem_ff[k-1], 1'b0};
         assign d_cur  = den_ff[k-1];
         assign quo_in = {quo_ff[k-1][QUO_W-2:0], ge};
      end

      assign dext = {1'b0, d_cur};
      assign ge   = (r2 >= dext);

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < DIV_STEPS - 1) begin : g_keep
         logic [WIDE_W-1:0] rem_in;
         assign rem_in = ge ? WIDE_W'(r2 - dext) : r2[WIDE_W-1:0];
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= d_cur;
            end
         end
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int B = SQRT_STEPS - 1 - j;
      logic [QUO_W-1:0] rem_prev;
      logic [Q_W-1:0]   root_prev;
      logic [Q_W-1:0]   rt_in;
      logic [SQ_W-1:0]  delta;
      logic             ge;

      if (j == 0) begin : g_first
         assign rem_prev  = quo_ff[DIV_STEPS-1];
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = sr_ff[j-1];
         assign root_prev = rt_ff[j-1];
      end

      // (r + 2^B)^2 - r^2
      assign delta = (SQ_W'(root_prev) << (B + 1)) + (SQ_W'(1) << (2 * B));
      assign ge    = (SQ_W'(rem_prev) >= delta);
      assign rt_in = ge ? (root_prev | (Q_W'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (enable) begin
            rt_ff[j] <= rt_in;
         end
      end

      if (j < SQRT_STEPS - 1) begin : g_keep
         logic [QUO_W-1:0] sr_in;
         assign sr_in = ge ? QUO_W'(SQ_W'(rem_prev) - delta) : rem_prev;
         always_ff @(posedge clock) begin
            if (enable) begin
               sr_ff[j] <= sr_in;
            end
         end
      end
   end

   assign quotient = rt_ff[SQRT_STEPS-1];

endmodule

/* sv/vpaa_back.sv */
module vpaa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  vpaa_pkg::item_type                head,
   input  logic                              head_valid,
   output logic                              pop,
   input  logic [vpaa_pkg::THR_W-1:0]        threshold,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_cosine,
   output logic [vpaa_pkg::Q_W-1:0]          rsp_sine,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_x,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_y,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_z,
   output logic [1:0]                        rsp_status
);
   import vpaa_pkg::*;

   logic adv;

   // stage 1: coordinate products
   logic signed [PROD_W-1:0] aa_in [DIM], aa_ff [DIM];
   logic signed [PROD_W-1:0] bb_in [DIM], bb_ff [DIM];
   logic signed [PROD_W-1:0] ab_in [DIM], ab_ff [DIM];
   logic signed [PROD_W-1:0] jk_in [DIM], jk_ff [DIM];
   logic signed [PROD_W-1:0] kj_in [DIM], kj_ff [DIM];
   logic                     v1_ff, zl1_ff;

   // stage 2: sums
   logic [PROD_W-1:0]        a2_in, a2_ff, b2_in, b2_ff;
   logic signed [PROD_W+1:0] dot_in, dot_ff;
   logic signed [PROD_W:0]   cr_in [DIM], cr_ff [DIM];
   logic                     v2_ff, zl2_ff;

   // stage 3: magnitudes
   logic [PROD_W-1:0] dmag_in, dmag_ff;
   logic [PROD_W-1:0] cmag_in [DIM], cmag_ff [DIM];
   logic [PROD_W-1:0] a2_3_ff, b2_3_ff;
   side_type          sd3_in, sd3_ff;
   logic              v3_ff;

   // stage 4: 32x32 partial products
   logic [PROD_W-1:0] opx [NLANE], opy [NLANE];
   logic [PROD_W-1:0] pp_in [NLANE][4], pp_ff [NLANE][4];
   side_type          sd4_ff;
   logic              v4_ff;

   // stage 5: wide products
   logic [WIDE_W-1:0] wide_in [NLANE], wide_ff [NLANE];
   side_type          sd5_ff;
   logic              v5_ff;

   // stage 6: |a x b|^2
   logic [WIDE_W-1:0] c2_in, c2_ff, p6_ff, dd6_ff;
   logic [WIDE_W-1:0] cc6_ff [DIM];
   side_type          sd6_ff, sd_entry;
   logic              v6_ff;

   side_type             sdc_ff [RATIO_LAT];
   logic [RATIO_LAT-1:0] vc_ff;

   logic [Q_W-1:0] cos_q, sin_q;
   logic [Q_W-1:0] axis_q [DIM];

   side_type                 sd_last;
   logic signed [OUT_W-1:0]  cos_in, cos_ff;
   logic [Q_W-1:0]           sin_in, sin_ff;
   logic signed [OUT_W-1:0]  axis_in [DIM], axis_ff [DIM];
   status_type               status_in, status_ff;
   logic                     rsp_valid_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && head_valid;

   for (genvar i = 0; i < DIM; i++) begin : g_prod
      localparam int J = (i + 1) % DIM;
      localparam int K = (i + 2) % DIM;
      assign aa_in[i] = PROD_W'($signed(head.a[i])) * PROD_W'($signed(head.a[i]));
      assign bb_in[i] = PROD_W'($signed(head.b[i])) * PROD_W'($signed(head.b[i]));
      assign ab_in[i] = PROD_W'($signed(head.a[i])) * PROD_W'($signed(head.b[i]));
      assign jk_in[i] = PROD_W'($signed(head.a[J])) * PROD_W'($signed(head.b[K]));
      assign kj_in[i] = PROD_W'($signed(head.a[K])) * PROD_W'($signed(head.b[J]));
      assign cr_in[i] = (PROD_W + 1)'(jk_ff[i]) - (PROD_W + 1)'(kj_ff[i]);
      assign cmag_in[i] = cr_ff[i][PROD_W] ? PROD_W'(-cr_ff[i]) : PROD_W'(cr_ff[i]);
   end

   always_comb begin
      a2_in  = '0;
      b2_in  = '0;
      dot_in = '0;
      for (int i = 0; i < DIM; i++) begin
         a2_in  = a2_in + $unsigned(aa_ff[i]);
         b2_in  = b2_in + $unsigned(bb_ff[i]);
         dot_in = dot_in + (PROD_W + 2)'(ab_ff[i]);
      end
   end

   always_comb begin
      dmag_in         = dot_ff[PROD_W+1] ? PROD_W'(-dot_ff) : PROD_W'(dot_ff);
      sd3_in.zero_len = zl2_ff;
      sd3_in.dot_neg  = dot_ff[PROD_W+1];
      for (int i = 0; i < DIM; i++) begin
         sd3_in.cr_neg[i] = cr_ff[i][PROD_W];
      end
      sd3_in.c2_zero  = 1'b0;
   end

   always_comb begin
      opx[0] = a2_3_ff;
      opy[0] = b2_3_ff;
      opx[1] = dmag_ff;
      opy[1] = dmag_ff;
      for (int i = 0; i < DIM; i++) begin
         opx[2+i] = cmag_ff[i];
         opy[2+i] = cmag_ff[i];
      end
   end

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      assign pp_in[l][0] = PROD_W'(opx[l][COORD_W-1:0]) * PROD_W'(opy[l][COORD_W-1:0]);
      assign pp_in[l][1] = PROD_W'(opx[l][COORD_W-1:0]) * PROD_W'(opy[l][PROD_W-1:COORD_W]);
      assign pp_in[l][2] = PROD_W'(opx[l][PROD_W-1:COORD_W]) * PROD_W'(opy[l][COORD_W-1:0]);
      assign pp_in[l][3] = PROD_W'(opx[l][PROD_W-1:COORD_W])
                           * PROD_W'(opy[l][PROD_W-1:COORD_W]);
      assign wide_in[l]  = {pp_ff[l][3], pp_ff[l][0]}
                           + (WIDE_W'(pp_ff[l][1]) << COORD_W)
                           + (WIDE_W'(pp_ff[l][2]) << COORD_W);
   end

   always_comb begin
      c2_in = '0;
      for (int i = 0; i < DIM; i++) begin
         c2_in = c2_in + wide_ff[2+i];
      end
   end

   always_comb begin
      sd_entry         = sd6_ff;
      sd_entry.c2_zero = (c2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff   <= aa_in;
         bb_ff   <= bb_in;
         ab_ff   <= ab_in;
         jk_ff   <= jk_in;
         kj_ff   <= kj_in;
         zl1_ff  <= head.zero_len;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         dot_ff  <= dot_in;
         cr_ff   <= cr_in;
         zl2_ff  <= zl1_ff;
         dmag_ff <= dmag_in;
         cmag_ff <= cmag_in;
         a2_3_ff <= a2_ff;
         b2_3_ff <= b2_ff;
         sd3_ff  <= sd3_in;
         pp_ff   <= pp_in;
         sd4_ff  <= sd3_ff;
         wide_ff <= wide_in;
         sd5_ff  <= sd4_ff;
         c2_ff   <= c2_in;
         p6_ff   <= wide_ff[0];
         dd6_ff  <= wide_ff[1];
         for (int i = 0; i < DIM; i++) begin
            cc6_ff[i] <= wide_ff[2+i];
         end
         sd6_ff  <= sd5_ff;
         sdc_ff[0] <= sd_entry;
         for (int k = 1; k < RATIO_LAT; k++) begin
            sdc_ff[k] <= sdc_ff[k-1];
         end
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         axis_ff   <= axis_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         vc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= head_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         vc_ff        <= {vc_ff[RATIO_LAT-2:0], v6_ff};
         rsp_valid_ff <= vc_ff[RATIO_LAT-1];
      end
   end

   vpaa_ratio u_cos (
      .clock    (clock),
      .enable   (adv),
      .num      (dd6_ff),
      .den      (p6_ff),
      .quotient (cos_q)
   );

   vpaa_ratio u_sin (
      .clock    (clock),
      .enable   (adv),
      .num      (c2_ff),
      .den      (p6_ff),
      .quotient (sin_q)
   );

   for (genvar i = 0; i < DIM; i++) begin : g_axis
      vpaa_ratio u_axis (
         .clock    (clock),
         .enable   (adv),
         .num      (cc6_ff[i]),
         .den      (c2_ff),
         .quotient (axis_q[i])
      );
   end

   assign sd_last = sdc_ff[RATIO_LAT-1];

   always_comb begin
      cos_in    = '0;
      sin_in    = '0;
      status_in = STAT_OK;
      for (int i = 0; i < DIM; i++) begin
         axis_in[i] = '0;
      end
      if (sd_last.zero_len) begin
         status_in = STAT_ZERO;
      end else begin
         cos_in = sd_last.dot_neg ? -OUT_W'(cos_q) : OUT_W'(cos_q);
         sin_in = sin_q;
         if ((sin_q < Q_W'(threshold)) || sd_last.c2_zero) begin
            status_in = STAT_PARALLEL;
         end else begin
            for (int i = 0; i < DIM; i++) begin
               axis_in[i] = sd_last.cr_neg[i] ? -OUT_W'(axis_q[i]) : OUT_W'(axis_q[i]);
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cosine = cos_ff;
   assign rsp_sine   = sin_ff;
   assign rsp_axis_x = axis_ff[0];
   assign rsp_axis_y = axis_ff[1];
   assign rsp_axis_z = axis_ff[2];
   assign rsp_status = status_ff;

endmodule

/* sv/vector_pair_angle_axis.sv */
// Angle and axis between two 3-D vectors in Q16.16: cosine and unit axis in Q2.30, sine in Q1.30.
// Sustains one transaction per clock while the output is not stalled; a result passes six
// product and sum stages, then the 92-stage pipelined divide and square-root units (a
// 61-step restoring divide followed by a 31-step root). Requests go into a QUEUE_DEPTH-entry
// queue; a stalled result freezes the back pipeline only, and req_stall rises once the
// queue is full. Zero-length inputs give status 1 with all fields zero; a sine below the
// threshold register, or an exactly zero cross product, gives status 2 with the axis
// zero. Write the threshold only while idle.
module vector_pair_angle_axis #(
   parameter int QUEUE_DEPTH = vpaa_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_a_x,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_a_y,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_a_z,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_b_x,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_b_y,
   input  logic signed [vpaa_pkg::COORD_W-1:0] req_b_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_cosine,
   output logic [vpaa_pkg::Q_W-1:0]          rsp_sine,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_x,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_y,
   output logic signed [vpaa_pkg::OUT_W-1:0] rsp_axis_z,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vpaa_pkg::THR_W-1:0]        csr_wdata
);
   import vpaa_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             full;
   logic             push_valid;
   item_type         push_data;
   logic             pop;
   logic             head_valid;
   item_type         head;

   assign csr_ready = 1'b1;
   assign thr_in    = csr_valid ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   vpaa_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_a_x    (req_a_x),
      .req_a_y    (req_a_y),
      .req_a_z    (req_a_z),
      .req_b_x    (req_b_x),
      .req_b_y    (req_b_y),
      .req_b_z    (req_b_z),
      .full       (full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   vpaa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   vpaa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .threshold  (thr_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_cosine (rsp_cosine),
      .rsp_sine   (rsp_sine),
      .rsp_axis_x (rsp_axis_x),
      .rsp_axis_y (rsp_axis_y),
      .rsp_axis_z (rsp_axis_z),
      .rsp_status (rsp_status)
   );

`ifndef NO_ASSERTIONS
   a_zero_len_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_ZERO) |->
         (rsp_cosine == '0) && (rsp_sine == '0) && (rsp_axis_x == '0)
         && (rsp_axis_y == '0) && (rsp_axis_z == '0))
      else $error("zero-length transaction carries nonzero fields");

   a_parallel_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_PARALLEL) |->
         (rsp_axis_x == '0) && (rsp_axis_y == '0) && (rsp_axis_z == '0))
      else $error("parallel transaction carries a nonzero axis");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine <= 31'h4000_0000)
         && (rsp_cosine <= 32'sh4000_0000) && (rsp_cosine >= -32'sh4000_0000))
      else $error("cosine or sine exceeds one");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import vpaa_pkg::*;

   typedef struct {
      logic signed [31:0] cosine;
      logic [30:0]        sine;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      status_type         status;
   } angle_result_type;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   class angle_scoreboard;
      angle_result_type pending[$];
      logic [THR_W-1:0] thr;
      int errors;
      int results;

      function new();
         thr = THR_RESET;
         errors = 0;
         results = 0;
      endfunction

      function void report(string what);
         errors++;
         $display("mismatch @%0t result %0d: %s", $realtime, results, what);
      endfunction

      // largest q in [0, 1.0] with q^2 * den <= num_sq * 2^60
      function logic [30:0] ratio_q30(logic [255:0] num_sq, logic [255:0] den);
         logic [255:0] target;
         logic [30:0] q, t;
         target = num_sq << 60;
         q = 0;
         for (int b = 30; b >= 0; b--) begin
            t = q | (31'd1 << b);
            if (t > ONE_Q30) continue;
            if ((256'(t) * 256'(t)) * den <= target) q = t;
         end
         return q;
      endfunction

      function logic [255:0] mag(logic signed [79:0] v);
         return (v < 0) ? 256'(-v) : 256'(v);
      endfunction

      function angle_result_type predict_angle(logic signed [31:0] a_in[3],
                                               logic signed [31:0] b_in[3]);
         angle_result_type r;
         logic signed [79:0] av[3], bv[3], cr[3], dot;
         logic [255:0] a2, b2, p, c2;
         logic [30:0] cq, sq, xq;
         int j, k;
         r = '{0, 0, 0, 0, 0, STAT_OK};
         a2 = 0; b2 = 0; dot = 0;
         for (int i = 0; i < 3; i++) begin
            av[i] = a_in[i];
            bv[i] = b_in[i];
            a2 += 256'(av[i] * av[i]);
            b2 += 256'(bv[i] * bv[i]);
            dot += av[i] * bv[i];
         end
         if (a2 == 0 || b2 == 0) begin
            r.status = STAT_ZERO;
            return r;
         end
         p = a2 * b2;
         c2 = 0;
         for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            cr[i] = av[j] * bv[k] - av[k] * bv[j];
            c2 += mag(cr[i]) * mag(cr[i]);
         end
         cq = ratio_q30(mag(dot) * mag(dot), p);
         sq = ratio_q30(c2, p);
         r.cosine = (dot < 0) ? -32'(cq) : 32'(cq);
         r.sine = sq;
         if (sq < 31'(thr) || c2 == 0) begin
            r.status = STAT_PARALLEL;
            return r;
         end
         for (int i = 0; i < 3; i++) begin
            xq = ratio_q30(mag(cr[i]) * mag(cr[i]), c2);
            if (i == 0) r.axis_x = (cr[i] < 0) ? -32'(xq) : 32'(xq);
            if (i == 1) r.axis_y = (cr[i] < 0) ? -32'(xq) : 32'(xq);
            if (i == 2) r.axis_z = (cr[i] < 0) ? -32'(xq) : 32'(xq);
         end
         return r;
      endfunction

      function void note(logic signed [31:0] a_in[3], logic signed [31:0] b_in[3]);
         pending.push_back(predict_angle(a_in, b_in));
      endfunction

      function void check(angle_result_type got);
         angle_result_type e;
         if (pending.size() == 0) begin
            report("result with nothing expected");
            results++;
            return;
         end
         e = pending.pop_front();
         if (got.cosine !== e.cosine)
            report($sformatf("cos %h exp %h", got.cosine, e.cosine));
         if (got.sine !== e.sine)
            report($sformatf("sin %h exp %h", got.sine, e.sine));
         if (got.axis_x !== e.axis_x)
            report($sformatf("axis_x %h exp %h", got.axis_x, e.axis_x));
         if (got.axis_y !== e.axis_y)
            report($sformatf("axis_y %h exp %h", got.axis_y, e.axis_y));
         if (got.axis_z !== e.axis_z)
            report($sformatf("axis_z %h exp %h", got.axis_z, e.axis_z));
         if (got.status !== e.status)
            report($sformatf("status %0d exp %0d", got.status, e.status));
         results++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_a_x = 0, req_a_y = 0, req_a_z = 0;
   logic signed [31:0] req_b_x = 0, req_b_y = 0, req_b_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_cosine, rsp_axis_x, rsp_axis_y, rsp_axis_z;
   logic [30:0] rsp_sine;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [THR_W-1:0] csr_wdata = 0;

   angle_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int sent = 0;
   int thr_writes = 0;

   vector_pair_angle_axis uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cosine(rsp_cosine), .rsp_sine(rsp_sine),
      .rsp_axis_x(rsp_axis_x), .rsp_axis_y(rsp_axis_y), .rsp_axis_z(rsp_axis_z),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      angle_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.cosine = rsp_cosine;
         got.sine = rsp_sine;
         got.axis_x = rsp_axis_x;
         got.axis_y = rsp_axis_y;
         got.axis_z = rsp_axis_z;
         got.status = status_type'(rsp_status);
         sb.check(got);
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic send_pair(logic signed [31:0] a_in[3], logic signed [31:0] b_in[3]);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_a_x <= a_in[0]; req_a_y <= a_in[1]; req_a_z <= a_in[2];
      req_b_x <= b_in[0]; req_b_y <= b_in[1]; req_b_z <= b_in[2];
      do @(posedge clock); while (req_stall);
      sb.note(a_in, b_in);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      drain();
      csr_valid <= 1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.thr = v;
      thr_writes++;
   endtask

   task automatic send_coords(logic signed [31:0] ax, logic signed [31:0] ay,
                              logic signed [31:0] az, logic signed [31:0] bx,
                              logic signed [31:0] by, logic signed [31:0] bz);
      logic signed [31:0] a_in[3], b_in[3];
      a_in = '{ax, ay, az};
      b_in = '{bx, by, bz};
      send_pair(a_in, b_in);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(32'h3_ffff)) - 32'sh2_0000;
         2: case ($urandom_range(4))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         default: return 32'sh1_0000 * ($signed($urandom_range(16)) - 8);
      endcase
   endfunction

   task automatic send_random();
      logic signed [31:0] a_in[3], b_in[3];
      int mode, kf;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         a_in[i] = rand_coord();
         b_in[i] = rand_coord();
      end
      if (mode == 0) begin
         if ($urandom_range(1)) a_in = '{0, 0, 0};
         else b_in = '{0, 0, 0};
      end else if (mode <= 2) begin
         // scaled copy, sometimes nudged so the sine lands near the threshold
         kf = $signed($urandom_range(4)) - 2;
         if (kf == 0) kf = 1;
         for (int i = 0; i < 3; i++) begin
            a_in[i] = a_in[i] >>> 2;
            b_in[i] = a_in[i] * kf;
         end
         if (mode == 2) b_in[$urandom_range(2)] += $signed($urandom_range(64)) - 32;
      end
      send_pair(a_in, b_in);
   endtask

   initial begin
      #20_000_000;
      $display("FAIL vector_pair_angle_axis");
      $finish;
   end

   initial begin
      logic [THR_W-1:0] thr_list[4];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero lengths, parallel, antiparallel, orthogonal, extremes
      send_coords(0, 0, 0, 1, 2, 3);
      send_coords(1, 2, 3, 0, 0, 0);
      send_coords(0, 0, 0, 0, 0, 0);
      send_coords(32'sh1_0000, 0, 0, 32'sh1_0000, 0, 0);
      send_coords(32'sh1_0000, 0, 0, -32'sh1_0000, 0, 0);
      send_coords(32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0);
      send_coords(0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000);
      send_coords(0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0);
      send_coords(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_coords(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_coords(32'sh7fff_ffff, 32'sh8000_0000, 1, -1, 32'sh7fff_ffff, 0);
      send_coords(1, 0, 0, 0, 1, 0);
      send_coords(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 1, 0);
      send_coords(-1, -1, -1, 1, 1, 1);
      send_coords(32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh1_0000, 32'sh2_0000, 32'sh3_0001);

      write_threshold(0);
      send_coords(32'sh1_0000, 0, 0, 32'sh2_0000, 0, 0);
      send_coords(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 1, 0);
      write_threshold(16'hffff);
      send_coords(32'sh1_0000, 0, 0, 32'sh1_0000, 32'sh10, 0);
      send_coords(32'sh1_0000, 0, 0, 32'sh1_0000, 32'sh1_0000, 0);
      send_coords(1, 2, 3, 3, 2, 1);

      thr_list = '{16'd0, 16'hffff, 16'd1, 16'(($urandom_range(65535)))};
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thr_list[ph]);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         for (int n = 0; n < 400; n++) begin
            send_random();
            if (ph == 1 && n == 200) begin
               req_valid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
      end

      stall_pct = 0;
      drain();
      $display("covered %0d vector pairs, %0d results, %0d threshold writes, 4 traffic phases",
               sent, sb.results, thr_writes);
      if (sb.errors == 0)
         $display("PASS vector_pair_angle_axis");
      else
         $display("FAIL vector_pair_angle_axis");
      $finish;
   end

endmodule
